@@ sv/dgp_pkg.sv @@
// Shared constants, types and register codes for the dashed grid pattern pipeline.
package dgp_pkg;

  localparam int MAX_FRAME_WIDTH  = 4096;
  localparam int MAX_FRAME_HEIGHT = 4096;

  localparam int PIX_W    = 12;
  localparam int OFF_W    = 13;
  localparam int CELL_W   = 10;
  localparam int DASH_W   = 9;
  localparam int RGBA_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Signed difference of pixel and grid centre, and the remainder dividend.
  localparam int DIFF_W  = 15;
  localparam int DIVID_W = 14;

  // Remainder pipeline: two restoring steps per register stage.
  localparam int STEPS_PER_STAGE = 2;
  localparam int MOD_STAGES      = DIVID_W / STEPS_PER_STAGE;
  localparam int LANES           = 4;

  // Lane assignment inside the remainder pipeline.
  localparam int LANE_X_CELL = 0;
  localparam int LANE_Y_CELL = 1;
  localparam int LANE_X_DASH = 2;
  localparam int LANE_Y_DASH = 3;

  // Reciprocal of three for ten bit operands: floor(c * 683 / 2048) == c / 3.
  localparam int          RECIP3_W = 11;
  localparam logic [10:0] RECIP3   = 11'd683;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_X_OFFSET = 3'd0,
    REG_GRID_Y_OFFSET = 3'd1,
    REG_CELL_SIZE     = 3'd2,
    REG_STROKE_WIDTH  = 3'd3,
    REG_LINE_RGBA     = 3'd4,
    REG_FILL_RGBA     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [OFF_W-1:0] x_off;
    logic signed [OFF_W-1:0] y_off;
    logic [CELL_W-1:0]       cell_size;
    logic [CELL_W-1:0]       stroke;
    logic [RGBA_W-1:0]       line_rgba;
    logic [RGBA_W-1:0]       fill_rgba;
    logic [CELL_W-2:0]       half_cell;
    logic [DASH_W-1:0]       dash;
    logic [DASH_W-3:0]       dash_quarter;
    logic [DASH_W-2:0]       dash_half;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0]  rem;
    logic [DIVID_W-1:0] bits;
  } mod_lane_t;

  typedef struct packed {
    logic                  in_frame;
    mod_lane_t [LANES-1:0] lanes;
  } pipe_t;

endpackage

@@ sv/dashed_grid_pattern_pixel.sv @@
// Top level of the dashed grid test pattern pixel pipeline.
//
// Usage: each transaction on the input channel (in_valid, in_ready) carries one
// pixel coordinate, pixel_x and pixel_y. Each produces exactly one transaction on
// the output channel (out_valid, out_ready) carrying the chosen colour pixel_rgba
// and the on_line flag, in the same order as the inputs arrived.
// The pipeline has ten register stages: two form the axis distances, seven run
// the restoring remainder unit (two bits per stage, four lanes side by side) and
// one holds the result. While the receiver keeps taking results, a new pixel
// can be accepted every cycle, so the sustained rate is one pixel per clock.
// Each stage has its own valid bit and takes new data when it is empty or when
// the stage after it moves on, so a stalled receiver fills the empty stages first
// and only then holds off the sender; nothing is dropped or duplicated.
// The configuration port writes one register per cycle when cfg_we is high; it
// is meant to be used only while the pipeline is empty. Synchronous reset
// empties the pipeline and loads the default grid: cell size 60, stroke 2,
// offsets zero, a red line colour and a transparent black background.
module dashed_grid_pattern_pixel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dgp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dgp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dgp_pkg::PIX_W-1:0]      pixel_x,
  input  logic [dgp_pkg::PIX_W-1:0]      pixel_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dgp_pkg::RGBA_W-1:0]     pixel_rgba,
  output logic                           on_line
);
  import dgp_pkg::*;

  // Configuration registers, including the dash length derived from the cell
  // size at the moment it is written, so no divider sits in the data path.
  cfg_t cfg;

  // Valid, ready and data at each boundary of the remainder pipeline. Index 0
  // is the output of the distance stages; index MOD_STAGES feeds the colour
  // stage.
  logic  mod_valid [MOD_STAGES+1];
  logic  mod_ready [MOD_STAGES+1];
  pipe_t mod_data  [MOD_STAGES+1];

  dgp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Distances from the cell centre on each axis, plus the same distances
  // advanced by a quarter dash for the dash phase test.
  dgp_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .dn_valid (mod_valid[0]),
    .dn_ready (mod_ready[0]),
    .dn_data  (mod_data[0])
  );

  // The remainders modulo the cell size and modulo the dash length are formed
  // bit by bit, most significant dividend bit first, across these stages.
  for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
    dgp_mod_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .up_valid (mod_valid[g]),
      .up_ready (mod_ready[g]),
      .up_data  (mod_data[g]),
      .dn_valid (mod_valid[g+1]),
      .dn_ready (mod_ready[g+1]),
      .dn_data  (mod_data[g+1])
    );
  end

  // A horizontal line needs the row distance within the stroke and the column
  // dash on; a vertical line the other way round. A zero cell size or a zero
  // dash length switches the grid off entirely.
  dgp_color u_color (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (mod_valid[MOD_STAGES]),
    .up_ready   (mod_ready[MOD_STAGES]),
    .up_data    (mod_data[MOD_STAGES]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_rgba (pixel_rgba),
    .on_line    (on_line)
  );

endmodule

@@ sv/dgp_cfg.sv @@
// Configuration registers with the derived cell and dash quantities.
module dgp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dgp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dgp_pkg::CFG_DATA_W-1:0] cfg_data,
  output dgp_pkg::cfg_t                cfg
);
  import dgp_pkg::*;

  logic [CELL_W+RECIP3_W-1:0] dash_prod;

  assign dash_prod = cfg_data[CELL_W-1:0] * RECIP3;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_off        <= '0;
      cfg.y_off        <= '0;
      cfg.cell_size    <= CELL_W'(60);
      cfg.stroke       <= CELL_W'(2);
      cfg.line_rgba    <= 32'hFFC0_0000;
      cfg.fill_rgba    <= '0;
      cfg.half_cell    <= (CELL_W-1)'(30);
      cfg.dash         <= DASH_W'(20);
      cfg.dash_quarter <= (DASH_W-2)'(5);
      cfg.dash_half    <= (DASH_W-1)'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_X_OFFSET: cfg.x_off <= signed'(cfg_data[OFF_W-1:0]);
        REG_GRID_Y_OFFSET: cfg.y_off <= signed'(cfg_data[OFF_W-1:0]);
        REG_CELL_SIZE: begin
          cfg.cell_size    <= cfg_data[CELL_W-1:0];
          cfg.half_cell    <= cfg_data[CELL_W-1:1];
          cfg.dash         <= dash_prod[RECIP3_W+DASH_W-1:RECIP3_W];
          cfg.dash_quarter <= dash_prod[RECIP3_W+DASH_W-1:RECIP3_W+2];
          cfg.dash_half    <= dash_prod[RECIP3_W+DASH_W-1:RECIP3_W+1];
        end
        REG_STROKE_WIDTH: cfg.stroke    <= cfg_data[CELL_W-1:0];
        REG_LINE_RGBA:    cfg.line_rgba <= cfg_data[RGBA_W-1:0];
        REG_FILL_RGBA:    cfg.fill_rgba <= cfg_data[RGBA_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/dgp_dist.sv @@
// Two pipeline stages forming the axis distances and the remainder dividends.
module dgp_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  dgp_pkg::cfg_t               cfg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic [dgp_pkg::PIX_W-1:0]   pixel_x,
  input  logic [dgp_pkg::PIX_W-1:0]   pixel_y,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output dgp_pkg::pipe_t              dn_data
);
  import dgp_pkg::*;

  logic                     v1;
  logic                     ready1;
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic                     frame1;
  logic signed [DIFF_W-1:0] diff_x_next;
  logic signed [DIFF_W-1:0] diff_y_next;
  logic [DIVID_W-1:0]       dist_x;
  logic [DIVID_W-1:0]       dist_y;
  pipe_t                    pipe_next;

  // Stage one: signed distance from the centre of the grid cell.
  assign diff_x_next = signed'(DIFF_W'(pixel_x)) - DIFF_W'(cfg.x_off)
                       - signed'(DIFF_W'(cfg.half_cell));
  assign diff_y_next = signed'(DIFF_W'(pixel_y)) - DIFF_W'(cfg.y_off)
                       - signed'(DIFF_W'(cfg.half_cell));

  assign ready1   = !dn_valid || dn_ready;
  assign up_ready = !v1 || ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (up_ready) begin
      v1 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      diff_x <= diff_x_next;
      diff_y <= diff_y_next;
      frame1 <= (32'(pixel_x) < MAX_FRAME_WIDTH) && (32'(pixel_y) < MAX_FRAME_HEIGHT);
    end
  end

  // Stage two: absolute distance, and the distance shifted by a quarter dash.
  assign dist_x = diff_x[DIFF_W-1] ? DIVID_W'(-diff_x) : DIVID_W'(diff_x);
  assign dist_y = diff_y[DIFF_W-1] ? DIVID_W'(-diff_y) : DIVID_W'(diff_y);

  always_comb begin
    pipe_next.in_frame                = frame1;
    pipe_next.lanes[LANE_X_CELL].rem  = '0;
    pipe_next.lanes[LANE_X_CELL].bits = dist_x;
    pipe_next.lanes[LANE_Y_CELL].rem  = '0;
    pipe_next.lanes[LANE_Y_CELL].bits = dist_y;
    pipe_next.lanes[LANE_X_DASH].rem  = '0;
    pipe_next.lanes[LANE_X_DASH].bits = dist_x + DIVID_W'(cfg.dash_quarter);
    pipe_next.lanes[LANE_Y_DASH].rem  = '0;
    pipe_next.lanes[LANE_Y_DASH].bits = dist_y + DIVID_W'(cfg.dash_quarter);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ready1) begin
      dn_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && v1) begin
      dn_data <= pipe_next;
    end
  end

endmodule

@@ sv/dgp_mod_stage.sv @@
// One stage of the restoring remainder pipeline, shared by all four lanes.
module dgp_mod_stage (
  input  logic           clk,
  input  logic           rst,
  input  dgp_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  dgp_pkg::pipe_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dgp_pkg::pipe_t dn_data
);
  import dgp_pkg::*;

  pipe_t             pipe_next;
  logic [CELL_W:0]   trial;
  logic [CELL_W-1:0] divisor;

  // Each step brings down one dividend bit and subtracts the divisor if it fits.
  always_comb begin
    pipe_next = up_data;
    trial     = '0;
    divisor   = '0;
    for (int l = 0; l < LANES; l++) begin
      divisor = (l == LANE_X_CELL || l == LANE_Y_CELL) ? cfg.cell_size
                                                       : CELL_W'(cfg.dash);
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        trial = {pipe_next.lanes[l].rem, pipe_next.lanes[l].bits[DIVID_W-1]};
        if (trial >= {1'b0, divisor}) begin
          trial = trial - {1'b0, divisor};
        end
        pipe_next.lanes[l].rem  = trial[CELL_W-1:0];
        pipe_next.lanes[l].bits = {pipe_next.lanes[l].bits[DIVID_W-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= pipe_next;
    end
  end

endmodule

@@ sv/dgp_color.sv @@
// Output stage: line and dash tests, colour selection and the result register.
module dgp_color (
  input  logic                       clk,
  input  logic                       rst,
  input  dgp_pkg::cfg_t              cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  dgp_pkg::pipe_t             up_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dgp_pkg::RGBA_W-1:0] pixel_rgba,
  output logic                       on_line
);
  import dgp_pkg::*;

  logic hit_x;
  logic hit_y;
  logic dash_x;
  logic dash_y;
  logic on_next;

  assign hit_x  = (cfg.cell_size != '0) &&
                  (up_data.lanes[LANE_X_CELL].rem < cfg.stroke);
  assign hit_y  = (cfg.cell_size != '0) &&
                  (up_data.lanes[LANE_Y_CELL].rem < cfg.stroke);
  assign dash_x = (cfg.dash != '0) &&
                  (up_data.lanes[LANE_X_DASH].rem < CELL_W'(cfg.dash_half));
  assign dash_y = (cfg.dash != '0) &&
                  (up_data.lanes[LANE_Y_DASH].rem < CELL_W'(cfg.dash_half));
  assign on_next = up_data.in_frame && ((hit_y && dash_x) || (hit_x && dash_y));

  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      on_line    <= on_next;
      pixel_rgba <= on_next ? cfg.line_rgba : cfg.fill_rgba;
    end
  end

endmodule
